[src/uad_pkg.sv]
// Shared types, constants and helpers for the unsigned to ASCII digit converter.
package uad_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT
    } state_t;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;
    localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_F    = 7'h46;

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] code;
        if (d < DEC_BASE)
        begin
            code = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            code = CHAR_A + CHAR_W'(d - DEC_BASE);
        end
        return code;
    endfunction

endpackage

[src/uad_dabble.sv]
// One shift-and-add-3 step of binary to BCD conversion over all digits.
module uad_dabble #(
    parameter int unsigned NUM_DIGITS = 10
) (
    input  logic [NUM_DIGITS*uad_pkg::DIGIT_W-1:0] bcd_cur,
    input  logic                                   bit_in,
    output logic [NUM_DIGITS*uad_pkg::DIGIT_W-1:0] bcd_nxt
);
    import uad_pkg::*;

    localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;

    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_cur[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN)
            begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_cur[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
            end
            else
            begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_cur[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign bcd_nxt = {adj[BCD_W-2:0], bit_in};

endmodule

[src/unsigned_to_ascii_digits.sv]
// Top level: converts an unsigned word to ASCII decimal or hex digits, MSB first.
// Decimal: a load step, then one shift-and-add-3 step per input bit (one bit per cycle in
// the shared BCD adjust unit), then a strip step per suppressed leading zero plus a final one,
// then the characters are emitted in turn, each one waiting while the output is stalled.
// Hex skips the conversion. Next word taken after the last char loads.
// rst_n clears the sequencer and the output valid asynchronously; no other state.
module unsigned_to_ascii_digits #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic                         op,
    input  logic [VALUE_WIDTH-1:0]       value,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic [uad_pkg::CHAR_W-1:0]   char_code,
    output logic                         last
);
    import uad_pkg::*;

    localparam int unsigned DEC_DIGITS = (VALUE_WIDTH * 77) / 256 + 1;
    localparam int unsigned HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int unsigned NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
    localparam int unsigned BIT_W      = $clog2(VALUE_WIDTH);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       dig_reg, dig_next;
    logic                   dst_valid_reg, dst_valid_next;
    logic [CHAR_W-1:0]      char_code_reg, char_code_next;
    logic                   last_reg, last_next;

    logic [BCD_W-1:0]       bcd_step;
    logic [DIGIT_W-1:0]     dig_arr [NUM_DIGITS];
    logic [DIGIT_W-1:0]     cur_digit;
    logic                   src_accept;
    logic                   out_free;

    uad_dabble #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .bcd_cur (dig_reg),
        .bit_in  (bin_reg[VALUE_WIDTH-1]),
        .bcd_nxt (bcd_step)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            dig_arr[i] = dig_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    assign cur_digit  = dig_arr[pos_reg];
    assign src_stall  = (state_reg != ST_IDLE);
    assign src_accept = src_valid && !src_stall;
    assign out_free   = !dst_valid_reg || !dst_stall;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        bin_next       = bin_reg;
        dig_next       = dig_reg;
        dst_valid_next = dst_valid_reg && dst_stall;
        char_code_next = char_code_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (src_accept)
                begin
                    if (op == OP_HEX)
                    begin
                        dig_next   = BCD_W'(value);
                        pos_next   = IDX_W'(HEX_DIGITS - 1);
                        state_next = ST_STRIP;
                    end
                    else
                    begin
                        dig_next   = '0;
                        bin_next   = value;
                        bit_next   = BIT_W'(VALUE_WIDTH - 1);
                        pos_next   = IDX_W'(DEC_DIGITS - 1);
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next = bcd_step;
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (pos_reg != '0 && cur_digit == '0)
                begin
                    pos_next = pos_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    dst_valid_next = 1'b1;
                    char_code_next = digit_to_ascii(cur_digit);
                    last_next      = (pos_reg == '0);
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        bit_reg       <= bit_next;
        bin_reg       <= bin_next;
        dig_reg       <= dig_next;
        char_code_reg <= char_code_next;
        last_reg      <= last_next;
    end

    assign dst_valid = dst_valid_reg;
    assign char_code = char_code_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) ||
                      (char_code >= CHAR_A && char_code <= CHAR_F))
        else $error("char_code outside digit range");

    a_dec_start: assert property (@(posedge clk) disable iff (!rst_n)
        src_accept && op == OP_DEC |=> state_reg == ST_CONV)
        else $error("decimal word did not start conversion");

    a_hex_start: assert property (@(posedge clk) disable iff (!rst_n)
        src_accept && op == OP_HEX |=> state_reg == ST_STRIP)
        else $error("hex word did not skip conversion");

    a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && bit_reg == '0 |=> state_reg == ST_STRIP)
        else $error("conversion did not end after last bit");

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && out_free && pos_reg == '0 |=> dst_valid && last)
        else $error("final digit not flagged last");
`endif

endmodule

[tb/tb_unsigned_to_ascii_digits.sv]
// Testbench for unsigned_to_ascii_digits: directed and random words checked per digit.
module tb_unsigned_to_ascii_digits;
    import uad_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } digit_char_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              src_valid;
    logic              src_stall;
    logic              op;
    logic [31:0]       value;
    logic              dst_valid;
    logic              dst_stall = 1'b0;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    digit_char_t digits_expected[$];
    int unsigned mismatch_count = 0;
    int unsigned src_gap_max = 0;
    int unsigned dst_gap_max = 0;
    int unsigned stall_left = 0;

    unsigned_to_ascii_digits dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .op        (op),
        .value     (value),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .char_code (char_code),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // digits are produced least significant first, then queued most significant first
    function automatic void push_expected_digits(input logic base_sel, input logic [31:0] number);
        logic [31:0]       rest;
        logic [31:0]       radix;
        logic [31:0]       d;
        logic [CHAR_W-1:0] rev[$];
        digit_char_t       entry;
        rest = number;
        radix = (base_sel == OP_HEX) ? 32'd16 : 32'd10;
        do
        begin
            d = rest % radix;
            rev.push_back((d >= 32'd10) ? CHAR_A + CHAR_W'(d - 32'd10) : CHAR_ZERO + CHAR_W'(d));
            rest = rest / radix;
        end
        while (rest != 0);
        while (rev.size() != 0)
        begin
            entry.char_code = rev.pop_back();
            entry.last = (rev.size() == 0);
            digits_expected.push_back(entry);
        end
    endfunction

    task automatic check_digit(input logic [CHAR_W-1:0] got_char, input logic got_last);
        digit_char_t want;
        if (digits_expected.size() == 0)
        begin
            report_mismatch($sformatf("unexpected char 0x%02h last %0b", got_char, got_last));
        end
        else
        begin
            want = digits_expected.pop_front();
            if (got_char !== want.char_code)
            begin
                report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                          got_char, want.char_code));
            end
            if (got_last !== want.last)
            begin
                report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                          got_last, want.last, want.char_code));
            end
        end
    endtask

    // sink: check each accepted character, then hold stall for a random count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                check_digit(char_code, last);
                stall_left = $urandom_range(dst_gap_max, 0);
                dst_stall <= (stall_left != 0);
            end
            else if (stall_left > 1)
            begin
                stall_left = stall_left - 1;
            end
            else
            begin
                stall_left = 0;
                dst_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic base_sel, input logic [31:0] number);
        int unsigned gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap != 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        op <= base_sel;
        value <= number;
        do
        begin
            @(posedge clk);
        end
        while (src_stall);
        push_expected_digits(base_sel, number);
    endtask

    // random bit length so short and long digit strings both show up
    function automatic logic [31:0] random_number();
        int unsigned nbits;
        logic [31:0] v;
        nbits = $urandom_range(32, 0);
        v = $urandom;
        if (nbits < 32)
        begin
            v = v & ((32'd1 << nbits) - 32'd1);
        end
        return v;
    endfunction

    task automatic run_random_words(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_word(($urandom_range(1, 0) != 0) ? OP_HEX : OP_DEC, random_number());
        end
    endtask

    task automatic test_zero();
        src_gap_max = 0;
        dst_gap_max = 0;
        send_word(OP_DEC, 32'd0);
        send_word(OP_HEX, 32'd0);
    endtask

    task automatic test_extremes();
        src_gap_max = 3;
        dst_gap_max = 3;
        send_word(OP_DEC, 32'hFFFF_FFFF);
        send_word(OP_HEX, 32'hFFFF_FFFF);
        send_word(OP_DEC, 32'h8000_0000);
        send_word(OP_HEX, 32'h8000_0000);
        send_word(OP_DEC, 32'd1);
        send_word(OP_HEX, 32'd1);
    endtask

    task automatic test_digit_boundaries();
        src_gap_max = 0;
        dst_gap_max = 2;
        send_word(OP_DEC, 32'd9);
        send_word(OP_DEC, 32'd10);
        send_word(OP_DEC, 32'd99);
        send_word(OP_DEC, 32'd100);
        send_word(OP_DEC, 32'd999_999_999);
        send_word(OP_DEC, 32'd1_000_000_000);
        send_word(OP_DEC, 32'd1_234_567_890);
        send_word(OP_HEX, 32'h0000_000A);
        send_word(OP_HEX, 32'h0000_000F);
        send_word(OP_HEX, 32'h0000_0010);
        send_word(OP_HEX, 32'h0FFF_FFFF);
        send_word(OP_HEX, 32'h1000_0000);
        send_word(OP_HEX, 32'hFEDC_BA98);
        send_word(OP_HEX, 32'h0123_4567);
    endtask

    task automatic test_random_streaming();
        src_gap_max = 0;
        dst_gap_max = 0;
        run_random_words(70);
    endtask

    task automatic test_random_throttled();
        src_gap_max = 13;
        dst_gap_max = 13;
        run_random_words(130);
    endtask

    task automatic test_random_backpressure();
        src_gap_max = 0;
        dst_gap_max = 13;
        run_random_words(50);
    endtask

    initial
    begin
        rst_n = 1'b0;
        src_valid = 1'b0;
        op = OP_DEC;
        value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_zero();
        test_extremes();
        test_digit_boundaries();
        test_random_streaming();
        test_random_throttled();
        test_random_backpressure();
        src_valid <= 1'b0;
        while (digits_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
